@@ rtl/core/ppsu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Potts site update package
// Shared widths, register codes and the configuration bundle of the block.
// ----------------------------------------------------------------------------
package ppsu_pkg;

  localparam int MAX_NEIGHBORS   = 8;
  localparam int SPIN_BITS       = 8;
  localparam int RAND_BITS       = 16;

  localparam int NUM_SPINS_BITS  = 8;
  localparam int COUNT_BITS      = 4;
  localparam int ENERGY_BITS     = $clog2(MAX_NEIGHBORS + 1);
  localparam int PACKED_BITS     = MAX_NEIGHBORS * SPIN_BITS;
  localparam int ACCEPT_BITS     = 16;

  localparam int FACTOR_BITS     = 16;
  localparam int FACTOR_LANES    = 8;
  localparam int LANE_BITS       = $clog2(FACTOR_LANES);
  localparam int TABLE_WORD_BITS = 64;

  localparam int PROD_BITS       = NUM_SPINS_BITS + RAND_BITS;
  localparam int PROP_BITS       = NUM_SPINS_BITS + 1;

  localparam int CFG_DATA_BITS   = 64;
  localparam int CFG_INDEX_BITS  = 2;

  localparam logic [NUM_SPINS_BITS-1:0] NUM_SPINS_RESET = NUM_SPINS_BITS'(2);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_NUM_SPINS   = 2'd0,
    REG_ZERO_TEMP   = 2'd1,
    REG_BOLTZ_LOW   = 2'd2,
    REG_BOLTZ_HIGH  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [NUM_SPINS_BITS-1:0]  num_spins;
    logic                       zero_temperature;
    logic [TABLE_WORD_BITS-1:0] boltz_factors_low;
    logic [TABLE_WORD_BITS-1:0] boltz_factors_high;
  } cfg_t;

endpackage

@@ rtl/core/ppsu_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Potts site update input channel
// Valid/ready channel carrying one site request.
// ----------------------------------------------------------------------------
interface ppsu_in_if import ppsu_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic [SPIN_BITS-1:0]   old_spin;
  logic [PACKED_BITS-1:0] neighbor_spins;
  logic [COUNT_BITS-1:0]  neighbor_count;
  logic [RAND_BITS-1:0]   rand_pick;
  logic [ACCEPT_BITS-1:0] rand_accept;

  modport source (
    output valid, old_spin, neighbor_spins, neighbor_count, rand_pick, rand_accept,
    input  ready
  );

  modport sink (
    input  valid, old_spin, neighbor_spins, neighbor_count, rand_pick, rand_accept,
    output ready
  );

endinterface

@@ rtl/core/ppsu_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Potts site update result channel
// Valid/ready channel carrying one site result.
// ----------------------------------------------------------------------------
interface ppsu_out_if import ppsu_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic [SPIN_BITS-1:0]   new_spin;
  logic                   spin_changed;
  logic                   mark_settled;
  logic [ENERGY_BITS-1:0] energy_before;

  modport source (
    output valid, new_spin, spin_changed, mark_settled, energy_before,
    input  ready
  );

  modport sink (
    input  valid, new_spin, spin_changed, mark_settled, energy_before,
    output ready
  );

endinterface

@@ rtl/core/ppsu_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Potts site update configuration registers
// Holds spin count, temperature mode and the Boltzmann factor table.
// ----------------------------------------------------------------------------
module ppsu_cfg_regs import ppsu_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
  output cfg_t                      cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_NUM_SPINS:  cfg_nxt.num_spins          = cfg_wdata[NUM_SPINS_BITS-1:0];
        REG_ZERO_TEMP:  cfg_nxt.zero_temperature   = cfg_wdata[0];
        REG_BOLTZ_LOW:  cfg_nxt.boltz_factors_low  = cfg_wdata[TABLE_WORD_BITS-1:0];
        REG_BOLTZ_HIGH: cfg_nxt.boltz_factors_high = cfg_wdata[TABLE_WORD_BITS-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_spins          <= NUM_SPINS_RESET;
      cfg_r.zero_temperature   <= 1'b0;
      cfg_r.boltz_factors_low  <= '0;
      cfg_r.boltz_factors_high <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/core/ppsu_energy.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Potts site update energy counter
// Counts the valid neighbors whose spin differs from a given spin.
// ----------------------------------------------------------------------------
module ppsu_energy import ppsu_pkg::*; (
  input  logic [SPIN_BITS-1:0]   self_spin,
  input  logic [PACKED_BITS-1:0] neighbor_spins,
  input  logic [COUNT_BITS-1:0]  neighbor_count,
  output logic [ENERGY_BITS-1:0] energy
);

  logic [MAX_NEIGHBORS-1:0] unlike;

  // The count is already saturated, so it never reaches past the last lane.
  always_comb begin
    for (int k = 0; k < MAX_NEIGHBORS; k++) begin
      unlike[k] = (COUNT_BITS'(k) < neighbor_count) &&
                  (neighbor_spins[k*SPIN_BITS +: SPIN_BITS] != self_spin);
    end
  end

  always_comb begin
    logic [ENERGY_BITS-1:0] acc;
    acc = '0;
    for (int k = 0; k < MAX_NEIGHBORS; k++) begin
      acc = acc + ENERGY_BITS'(unlike[k]);
    end
    energy = acc;
  end

endmodule

@@ rtl/core/potts_metropolis_site_update_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Potts Metropolis site update
// One lattice site per request: propose a spin, compare energies, accept or
// reject against the Boltzmann table, and return the new spin.
// ----------------------------------------------------------------------------
// Usage:
//   A request enters on in_if (valid/ready) with the site's spin, its packed
//   neighbor spins and count, and two uniform random numbers. Each request
//   yields exactly one result on out_if, in request order.
//   The configuration port writes one register per cycle in which cfg_we is
//   high; write it only while no request is in flight.
// Pipeline and throughput:
//   An accepted request is held in the input register, evaluated in one
//   combinational pass and loaded into the result register, which presents
//   it from then on. One request per cycle is sustained while the receiver
//   does not stall; the rate is set by the single proposal multiply plus the
//   energy compare and factor select between the two registers.
// Reset and stall:
//   rst_n (synchronous, active low) empties both pipeline registers and
//   restores the configuration defaults (two spin values, finite
//   temperature, zero factors). While the receiver stalls, the result
//   register holds, and one more request can still be taken into the input
//   register; the input side stalls only when both are full.
// ----------------------------------------------------------------------------
module potts_metropolis_site_update_top import ppsu_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  ppsu_in_if.sink                   in_if,
  ppsu_out_if.source                out_if,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

  cfg_t cfg;

  ppsu_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register stage.
  logic                   s1_valid_r, s1_valid_nxt;
  logic [SPIN_BITS-1:0]   s1_old_spin_r;
  logic [PACKED_BITS-1:0] s1_neighbors_r;
  logic [COUNT_BITS-1:0]  s1_count_r;
  logic [RAND_BITS-1:0]   s1_pick_r;
  logic [ACCEPT_BITS-1:0] s1_accept_r;

  // Result register stage.
  logic                   out_valid_r, out_valid_nxt;
  logic [SPIN_BITS-1:0]   out_new_spin_r;
  logic                   out_changed_r;
  logic                   out_settled_r;
  logic [ENERGY_BITS-1:0] out_energy_r;

  logic advance;
  logic in_take;

  // The result register moves whenever it is empty or being drained.
  assign advance   = !out_valid_r || out_if.ready;
  assign in_if.ready = !s1_valid_r || advance;
  assign in_take   = in_if.valid && in_if.ready;

  // Neighbor counts above the lattice limit are treated as full.
  logic [COUNT_BITS-1:0] count_sat;
  assign count_sat = (s1_count_r > COUNT_BITS'(MAX_NEIGHBORS)) ?
                     COUNT_BITS'(MAX_NEIGHBORS) : s1_count_r;

  // Proposed spin: scale the pick by the spin count, offset by one and clamp.
  logic [PROD_BITS-1:0]      product;
  logic [PROP_BITS-1:0]      prop_raw;
  logic [NUM_SPINS_BITS-1:0] prop_clamped;
  logic [SPIN_BITS-1:0]      proposed;

  assign product      = PROD_BITS'(cfg.num_spins) * PROD_BITS'(s1_pick_r);
  assign prop_raw     = {1'b0, product[PROD_BITS-1 -: NUM_SPINS_BITS]} + PROP_BITS'(1);
  assign prop_clamped = (prop_raw > {1'b0, cfg.num_spins}) ?
                        cfg.num_spins : prop_raw[NUM_SPINS_BITS-1:0];
  assign proposed     = prop_clamped[SPIN_BITS-1:0];

  logic [ENERGY_BITS-1:0] e_old;
  logic [ENERGY_BITS-1:0] e_new;

  ppsu_energy u_energy_old (
    .self_spin      (s1_old_spin_r),
    .neighbor_spins (s1_neighbors_r),
    .neighbor_count (count_sat),
    .energy         (e_old)
  );

  ppsu_energy u_energy_new (
    .self_spin      (proposed),
    .neighbor_spins (s1_neighbors_r),
    .neighbor_count (count_sat),
    .energy         (e_new)
  );

  // A rise d selects lane d-1 of the two table words, low word first.
  logic                                  rise;
  logic [ENERGY_BITS-1:0]                delta;
  logic [LANE_BITS-1:0]                  lane;
  logic [FACTOR_LANES*FACTOR_BITS-1:0]   table_bits;
  logic [FACTOR_BITS-1:0]                factor;
  logic                                  reject;
  logic [SPIN_BITS-1:0]                  new_spin;
  logic                                  settled;

  assign rise       = e_new > e_old;
  assign delta      = e_new - e_old;
  assign lane       = LANE_BITS'(delta - ENERGY_BITS'(1));
  assign table_bits = {cfg.boltz_factors_high, cfg.boltz_factors_low};
  assign factor     = table_bits[lane*FACTOR_BITS +: FACTOR_BITS];

  always_comb begin
    priority if (!rise) begin
      reject = 1'b0;
    end else if (cfg.zero_temperature) begin
      reject = 1'b1;
    end else begin
      reject = s1_accept_r > factor;
    end
  end

  assign new_spin = reject ? s1_old_spin_r : proposed;
  assign settled  = {1'b0, e_old, 1'b0} < (ENERGY_BITS + 2)'(count_sat);

  // Control next-state.
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (in_if.ready) begin
      s1_valid_nxt = in_if.valid;
    end
    if (advance) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_old_spin_r  <= in_if.old_spin;
      s1_neighbors_r <= in_if.neighbor_spins;
      s1_count_r     <= in_if.neighbor_count;
      s1_pick_r      <= in_if.rand_pick;
      s1_accept_r    <= in_if.rand_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_new_spin_r <= new_spin;
      out_changed_r  <= new_spin != s1_old_spin_r;
      out_settled_r  <= settled;
      out_energy_r   <= e_old;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.new_spin      = out_new_spin_r;
  assign out_if.spin_changed  = out_changed_r;
  assign out_if.mark_settled  = out_settled_r;
  assign out_if.energy_before = out_energy_r;

  // The input side stalls only when both stages are full and the sink stalls.
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (s1_valid_r && out_valid_r && !out_if.ready))
    else $error("input stalled without a full pipeline");

  // A held request moves into the result register whenever it can.
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance) |=> out_valid_r)
    else $error("request lost between stages");

  // At zero temperature an energy rise never changes the spin.
  a_zero_temp_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance && cfg.zero_temperature && rise) |=> !out_changed_r)
    else $error("energy rise accepted at zero temperature");

  // The reported energy never exceeds the neighbor limit.
  a_energy_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_energy_r <= ENERGY_BITS'(MAX_NEIGHBORS)))
    else $error("energy out of range");

endmodule
